// File: sv/rhh_pkg.sv
// Package: shared types and codes for the Robin Hood hash table.
`default_nettype none
package rhh_pkg;
   typedef logic [1:0] func_type;
   localparam func_type FUNC_GET    = 2'd0;
   localparam func_type FUNC_SET    = 2'd1;
   localparam func_type FUNC_REMOVE = 2'd2;

   typedef logic [1:0] status_type;
   localparam status_type ST_OK      = 2'd0;
   localparam status_type ST_UPDATED = 2'd1;
   localparam status_type ST_MISSING = 2'd2;
   localparam status_type ST_FULL    = 2'd3;
endpackage
`default_nettype wire

// File: sv/rhh_ram.sv
// Generic single-port RAM with registered read.
`default_nettype none
module rhh_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data <= mem_ff[addr];
   end
endmodule
`default_nettype wire

// File: sv/robin_hood_hash_table.sv
// Top level: Robin Hood hash table with a slot sequencer and backward-shift delete.
`default_nettype none
// Robin Hood hash table over SLOTS slots (a power of two). Each request is a get,
// set or remove, and any other code is answered as missing; exactly one response
// follows each request. One slot RAM port is shared by all phases. Every probed
// slot takes a read state that issues the address and a check state that tests
// the data. A write (swap, shift, insert, update) happens in the check state and
// adds no state of its own. A request is accepted in S_IDLE, walks the probe
// states and presents its response in S_RESP; an insert or a backward shift adds
// a read and a check per slot it walks. The response is held in S_RESP while
// rsp_ready is low.
// The block takes no request while one is in work or its response waits.
// Valid bits live in flip-flops (one per slot) so reset empties the table at once.
// The csr_ port writes entry_limit (reset 192); limits above SLOTS act as SLOTS.
module robin_hood_hash_table #(
   parameter int SLOTS      = 256,
   parameter int KEY_BITS   = 32,
   parameter int VALUE_BITS = 64
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire rhh_pkg::func_type   req_func,
   input  wire logic [31:0]         req_key_id,
   input  wire logic [31:0]         req_key_hash,
   input  wire logic [63:0]         req_write_value,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output rhh_pkg::status_type      rsp_status,
   output logic [63:0]              rsp_read_value,
   output logic [8:0]               rsp_live_entries,
   input  wire logic                csr_valid,
   output logic                     csr_ready,
   input  wire logic [8:0]          csr_entry_limit
);
   import rhh_pkg::*;

   localparam int IW = $clog2(SLOTS);
   localparam int CW = IW + 1;
   localparam int EW = KEY_BITS + IW + VALUE_BITS;   // key | home | value

   // sequencer states
   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_LREAD  = 3'd1;  // lookup: address issued
   localparam logic [2:0] S_LCHK   = 3'd2;  // lookup: data back
   localparam logic [2:0] S_IREAD  = 3'd3;  // insert walk
   localparam logic [2:0] S_ICHK   = 3'd4;
   localparam logic [2:0] S_DREAD  = 3'd5;  // backward shift
   localparam logic [2:0] S_DCHK   = 3'd6;
   localparam logic [2:0] S_RESP   = 3'd7;

   logic [2:0]        state_ff, state_in;
   func_type          func_ff, func_in;
   logic [KEY_BITS-1:0]   key_ff, key_in;
   logic [IW-1:0]     home_ff, home_in;
   logic [VALUE_BITS-1:0] val_ff, val_in;
   logic [IW-1:0]     idx_ff, idx_in;     // probe position
   logic [IW-1:0]     pos_ff, pos_in;     // shift destination
   logic [CW-1:0]     step_ff, step_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [8:0]        limit_ff;
   logic [SLOTS-1:0]  valid_ff, valid_in;
   status_type        status_ff, status_in;
   logic [63:0]       rdval_ff, rdval_in;

   logic              ram_we;
   logic [IW-1:0]     ram_addr;
   logic [EW-1:0]     ram_wdata, ram_rdata;

   rhh_ram #(.WIDTH(EW), .DEPTH(SLOTS)) u_slots (
      .clock(clock), .wr_en(ram_we), .addr(ram_addr),
      .wr_data(ram_wdata), .rd_data(ram_rdata)
   );

   // fields of the slot just read
   logic [KEY_BITS-1:0]   r_key;
   logic [IW-1:0]         r_home;
   logic [VALUE_BITS-1:0] r_val;
   assign {r_key, r_home, r_val} = ram_rdata;

   logic [IW-1:0] r_dist, my_dist, idx_nx;
   logic [CW-1:0] limit_eff;
   assign r_dist  = idx_ff - r_home;
   assign my_dist = idx_ff - home_ff;
   assign idx_nx  = idx_ff + 1'b1;
   assign limit_eff = (32'(limit_ff) > SLOTS) ? CW'(SLOTS) : CW'(limit_ff);

   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = (state_ff == S_RESP);
   assign rsp_status = status_ff;
   assign rsp_read_value = rdval_ff;
   assign rsp_live_entries = 9'(count_ff);

   always_comb begin
      state_in = state_ff; func_in = func_ff; key_in = key_ff; home_in = home_ff;
      val_in = val_ff; idx_in = idx_ff; pos_in = pos_ff; step_in = step_ff;
      count_in = count_ff; valid_in = valid_ff; status_in = status_ff;
      rdval_in = rdval_ff;
      ram_we = 1'b0; ram_addr = idx_ff; ram_wdata = {key_ff, home_ff, val_ff};
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               func_in  = req_func;
               key_in   = KEY_BITS'(req_key_id);
               home_in  = req_key_hash[IW-1:0];
               idx_in   = req_key_hash[IW-1:0];
               val_in   = VALUE_BITS'(req_write_value);
               step_in  = '0;
               rdval_in = '0;
               status_in = ST_MISSING;
               state_in = (req_func == FUNC_GET || req_func == FUNC_SET ||
                           req_func == FUNC_REMOVE) ? S_LREAD : S_RESP;
            end
         end
         S_LREAD: begin
            ram_addr = idx_ff;
            state_in = S_LCHK;
         end
         S_LCHK: begin
            if (!valid_ff[idx_ff] || step_ff > CW'(r_dist) || step_ff == CW'(SLOTS)) begin
               // not present
               if (func_ff == FUNC_SET) begin
                  if (count_ff >= limit_eff) begin
                     status_in = ST_FULL; state_in = S_RESP;
                  end else begin
                     status_in = ST_OK; idx_in = home_ff; state_in = S_IREAD;
                  end
               end else begin
                  state_in = S_RESP;
               end
            end else if (r_key == key_ff) begin
               if (func_ff == FUNC_GET) begin
                  status_in = ST_OK;
                  rdval_in = 64'(r_val);
                  state_in = S_RESP;
               end else if (func_ff == FUNC_SET) begin
                  ram_we = 1'b1; ram_addr = idx_ff;
                  ram_wdata = {r_key, r_home, val_ff};
                  status_in = ST_UPDATED; state_in = S_RESP;
               end else begin
                  status_in = ST_OK; pos_in = idx_ff; idx_in = idx_nx;
                  step_in = '0; state_in = S_DREAD;
               end
            end else begin
               step_in = step_ff + 1'b1; idx_in = idx_nx; state_in = S_LREAD;
            end
         end
         S_IREAD: begin
            ram_addr = idx_ff;
            state_in = S_ICHK;
         end
         S_ICHK: begin
            if (!valid_ff[idx_ff]) begin
               ram_we = 1'b1; valid_in[idx_ff] = 1'b1;
               count_in = count_ff + 1'b1; state_in = S_RESP;
            end else begin
               if (my_dist > r_dist) begin
                  // swap carried entry with the richer resident
                  ram_we = 1'b1;
                  key_in = r_key; home_in = r_home; val_in = r_val;
               end
               idx_in = idx_nx; state_in = S_IREAD;
            end
         end
         S_DREAD: begin
            ram_addr = idx_ff;   // idx = pos + 1
            state_in = S_DCHK;
         end
         S_DCHK: begin
            if (!valid_ff[idx_ff] || r_home == idx_ff || step_ff == CW'(SLOTS - 1)) begin
               valid_in[pos_ff] = 1'b0;
               count_in = count_ff - 1'b1;
               state_in = S_RESP;
            end else begin
               ram_we = 1'b1; ram_addr = pos_ff; ram_wdata = ram_rdata;
               pos_in = idx_ff; idx_in = idx_nx; step_in = step_ff + 1'b1;
               state_in = S_DREAD;
            end
         end
         S_RESP: begin
            if (rsp_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         valid_ff <= '0;
         limit_ff <= 9'd192;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         valid_ff <= valid_in;
         if (csr_valid) limit_ff <= csr_entry_limit;
      end
      func_ff <= func_in; key_ff <= key_in; home_ff <= home_in; val_ff <= val_in;
      idx_ff <= idx_in; pos_ff <= pos_in; step_ff <= step_in;
      status_ff <= status_in; rdval_ff <= rdval_in;
   end
endmodule
`default_nettype wire

// File: sim/robin_hood_hash_table_tb.sv
// Testbench: Robin Hood hash table checked against an in-bench table predictor.
`timescale 1ns / 1ps
`default_nettype none
module robin_hood_hash_table_tb;
   import rhh_pkg::*;

   localparam int NSLOT = 256;
   localparam int IDLE_LIMIT = 20000;
   localparam func_type FUNC_UNUSED = 2'd3;

   typedef struct packed {
      status_type  status;
      logic [63:0] read_value;
      logic [8:0]  live;
   } answer_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   func_type req_func = FUNC_GET;
   logic [31:0] req_key_id = '0;
   logic [31:0] req_key_hash = '0;
   logic [63:0] req_write_value = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   status_type rsp_status;
   logic [63:0] rsp_read_value;
   logic [8:0] rsp_live_entries;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [8:0] csr_entry_limit = '0;

   robin_hood_hash_table u_dut (
      .clock, .reset, .req_valid, .req_ready, .req_func, .req_key_id,
      .req_key_hash, .req_write_value, .rsp_valid, .rsp_ready, .rsp_status,
      .rsp_read_value, .rsp_live_entries, .csr_valid, .csr_ready, .csr_entry_limit
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state: mirror of the slot store
   bit          tbl_used[NSLOT];
   logic [31:0] tbl_key[NSLOT];
   logic [7:0]  tbl_home[NSLOT];
   logic [63:0] tbl_val[NSLOT];
   int          tbl_count;
   int          tbl_limit;

   answer_type  pending_answers[$];
   int          errors = 0;
   int          idle_cycles = 0;
   // keys recently used, so random requests hit live entries often
   logic [31:0] key_pool_id[$];
   logic [31:0] key_pool_hash[$];

   // stall patterns
   int          rsp_stall_mode = 0;
   int          burst_left = 0;

   function automatic int home_gap(int home, int idx);
      return (idx - home) & (NSLOT - 1);
   endfunction

   function automatic int find_slot(logic [31:0] key, int home);
      int idx;
      for (int s = 0; s < NSLOT; s++) begin
         idx = (home + s) & (NSLOT - 1);
         if (!tbl_used[idx]) return -1;
         if (s > home_gap(tbl_home[idx], idx)) return -1;
         if (tbl_key[idx] == key) return idx;
      end
      return -1;
   endfunction

   function automatic void place_key(logic [31:0] key, int home, logic [63:0] val);
      int idx;
      logic [31:0] tk;
      int th;
      logic [63:0] tv;
      idx = home;
      for (int n = 0; n < NSLOT; n++) begin
         if (!tbl_used[idx]) begin
            tbl_used[idx] = 1;
            tbl_key[idx] = key;
            tbl_home[idx] = home[7:0];
            tbl_val[idx] = val;
            tbl_count++;
            return;
         end
         if (home_gap(home, idx) > home_gap(tbl_home[idx], idx)) begin
            // carried entry is poorer: take the slot, carry the resident on
            tk = tbl_key[idx]; th = tbl_home[idx]; tv = tbl_val[idx];
            tbl_key[idx] = key; tbl_home[idx] = home[7:0]; tbl_val[idx] = val;
            key = tk; home = th; val = tv;
         end
         idx = (idx + 1) & (NSLOT - 1);
      end
   endfunction

   function automatic void shift_out(int pos);
      int nxt;
      for (int n = 0; n + 1 < NSLOT; n++) begin
         nxt = (pos + 1) & (NSLOT - 1);
         if (!tbl_used[nxt] || tbl_home[nxt] == nxt) break;
         tbl_key[pos] = tbl_key[nxt];
         tbl_home[pos] = tbl_home[nxt];
         tbl_val[pos] = tbl_val[nxt];
         pos = nxt;
      end
      tbl_used[pos] = 0;
      tbl_count--;
   endfunction

   function automatic answer_type table_answer(func_type f, logic [31:0] key,
                                               logic [31:0] hash, logic [63:0] val);
      answer_type a;
      int home;
      int at;
      int lim;
      home = hash[7:0];
      lim = (tbl_limit > NSLOT) ? NSLOT : tbl_limit;
      a.status = ST_MISSING;
      a.read_value = '0;
      at = -1;
      if (f != FUNC_UNUSED) at = find_slot(key, home);
      case (f)
         FUNC_GET: begin
            if (at >= 0) begin
               a.status = ST_OK;
               a.read_value = tbl_val[at];
            end
         end
         FUNC_SET: begin
            if (at >= 0) begin
               tbl_val[at] = val;
               a.status = ST_UPDATED;
            end else if (tbl_count >= lim) begin
               a.status = ST_FULL;
            end else begin
               place_key(key, home, val);
               a.status = ST_OK;
            end
         end
         FUNC_REMOVE: begin
            if (at >= 0) begin
               shift_out(at);
               a.status = ST_OK;
            end
         end
         default: ;
      endcase
      a.live = tbl_count[8:0];
      return a;
   endfunction

   // Send one request; predict at acceptance. Sender bursts with random gaps.
   task automatic send_request(func_type f, logic [31:0] key, logic [31:0] hash,
                               logic [63:0] val);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         if ($urandom_range(0, 2) != 0)
            repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_func <= f;
      req_key_id <= key;
      req_key_hash <= hash;
      req_write_value <= val;
      do @(posedge clock); while (!req_ready);
      pending_answers.push_back(table_answer(f, key, hash, val));
      if (f == FUNC_SET) begin
         key_pool_id.push_back(key);
         key_pool_hash.push_back(hash);
         if (key_pool_id.size() > 400) begin
            void'(key_pool_id.pop_front());
            void'(key_pool_hash.pop_front());
         end
      end
      req_valid <= 1'b0;
      // block is busy after acceptance anyway; next drive lands on a later edge
      @(posedge clock);
   endtask

   task automatic drain_answers();
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   // only between phases, with nothing outstanding
   task automatic write_limit(int lim);
      drain_answers();
      csr_valid <= 1'b1;
      csr_entry_limit <= lim[8:0];
      do @(posedge clock); while (!csr_ready);
      tbl_limit = lim;
      csr_valid <= 1'b0;
   endtask

   // response checker: compare each accepted response with the oldest prediction
   always @(posedge clock) begin
      answer_type exp_a;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_answers.size() == 0) begin
            $display("%0t: unexpected response status=%0d", $time, rsp_status);
            errors++;
         end else begin
            exp_a = pending_answers.pop_front();
            if (rsp_status !== exp_a.status) begin
               $display("%0t: status exp %0d got %0d", $time, exp_a.status, rsp_status);
               errors++;
            end
            if (rsp_read_value !== exp_a.read_value) begin
               $display("%0t: read_value exp %h got %h", $time, exp_a.read_value,
                        rsp_read_value);
               errors++;
            end
            if (rsp_live_entries !== exp_a.live) begin
               $display("%0t: live_entries exp %0d got %0d", $time, exp_a.live,
                        rsp_live_entries);
               errors++;
            end
         end
      end
   end

   // receiver stall pattern: modes change over time, one with no stall at all
   always @(posedge clock) begin
      if ($urandom_range(0, 63) == 0) rsp_stall_mode <= $urandom_range(0, 3);
      case (rsp_stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= ($urandom_range(0, 3) != 0);
         2: rsp_ready <= ($urandom_range(0, 1) != 0);
         default: rsp_ready <= ($urandom_range(0, 7) == 0);
      endcase
   end

   // watchdog: cycles with no accepted request, response or CSR write
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   // directed: extremes, all operations, unused code, collisions and wrap
   task automatic test_directed();
      send_request(FUNC_GET, 32'h0, 32'h0, '0);
      send_request(FUNC_REMOVE, 32'h0, 32'h0, '0);
      send_request(FUNC_SET, 32'h0, 32'h0, '0);
      send_request(FUNC_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '1);
      send_request(FUNC_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0);
      // update an existing key
      send_request(FUNC_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'h5555_AAAA_5555_AAAA);
      send_request(FUNC_GET, 32'hFFFF_FFFF, 32'h0000_00FF, '0);
      // collisions at the top slot wrap past slot zero
      for (int i = 1; i <= 4; i++)
         send_request(FUNC_SET, 32'h100 + i, 32'hABCD_00FF, 64'(i));
      send_request(FUNC_REMOVE, 32'hFFFF_FFFF, 32'hFF, '0);
      send_request(FUNC_GET, 32'h103, 32'hFF, '0);
      send_request(FUNC_REMOVE, 32'h101, 32'hFF, '0);
      send_request(FUNC_GET, 32'h104, 32'hFF, '0);
      send_request(FUNC_GET, 32'h0, 32'h0, '0);
      // unused function code leaves state alone
      send_request(FUNC_UNUSED, 32'h102, 32'hFF, '1);
      send_request(FUNC_GET, 32'h102, 32'hFF, '0);
      send_request(FUNC_GET, 32'h999, 32'hFF, '0);
   endtask

   // limits of zero and one, both below the current count
   task automatic test_limits();
      write_limit(0);
      send_request(FUNC_SET, 32'h777, 32'h12, '1);
      send_request(FUNC_SET, 32'h102, 32'hFF, 64'hC0DE);  // update at limit
      write_limit(1);
      send_request(FUNC_SET, 32'h778, 32'h13, '1);
      send_request(FUNC_REMOVE, 32'h102, 32'hFF, '0);
      send_request(FUNC_GET, 32'h104, 32'hFF, '0);
   endtask

   task automatic random_phase(int n, int hash_bits, int set_weight);
      int pick;
      int r;
      func_type f;
      logic [31:0] key;
      logic [31:0] hash;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(0, 99);
         if (r < set_weight) f = FUNC_SET;
         else if (r < set_weight + 25) f = FUNC_GET;
         else if (r < 97) f = FUNC_REMOVE;
         else f = FUNC_UNUSED;
         if (key_pool_id.size() != 0 && $urandom_range(0, 2) != 0) begin
            pick = $urandom_range(0, key_pool_id.size() - 1);
            key = key_pool_id[pick];
            hash = key_pool_hash[pick];
         end else begin
            key = $urandom();
            // narrow hash range crowds homes together for long probe runs
            hash = $urandom() & ~(32'hFF >> hash_bits << hash_bits) | ($urandom() & 32'hFFFF_FF00);
            hash[7:0] = hash[7:0] & 8'((1 << hash_bits) - 1);
         end
         send_request(f, key, hash, rand64());
      end
   endtask

   task automatic test_random();
      write_limit(256);
      random_phase(500, 8, 60);     // fill to full table
      write_limit(511);             // above slot count
      random_phase(300, 3, 50);     // heavy clustering
      write_limit(192);
      random_phase(500, 8, 45);
      write_limit(40);              // lowered below the count
      random_phase(375, 5, 40);
   endtask

   initial begin
      tbl_count = 0;
      tbl_limit = 192;
      for (int i = 0; i < NSLOT; i++) tbl_used[i] = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_limits();
      test_random();
      drain_answers();
      if (errors == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end
endmodule
`default_nettype wire
